>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heartbeat supervisor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sequence or implication property, clocked on the rising edge, off in reset.
`define MHS_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Plain condition that must hold at every clock edge out of reset.
`define MHS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error(msg);

`endif

>>> design/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg
// Types and constants shared by the heartbeat supervisor modules.
// ----------------------------------------------------------------------------
package mhs_pkg;

  localparam int SOURCES = 8;
  localparam int IDX_W   = $clog2(SOURCES);
  localparam int SRC_W   = 4;
  localparam int CMD_W   = 2;
  localparam int TS_W    = 32;
  localparam int TMO_W   = 20;
  localparam int ROLE_W  = 3;
  localparam int THR_W   = 20;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PUMP    = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_BASE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_UI_SOURCE    = 2'd1;
  localparam logic [1:0] REG_MON_SOURCE   = 2'd2;
  localparam logic [1:0] REG_ENABLE       = 2'd3;

  // register reset values
  localparam logic [TMO_W-1:0]  BASE_TIMEOUT_RST = 20'd4000;
  localparam logic [ROLE_W-1:0] UI_SOURCE_RST    = 3'd0;
  localparam logic [ROLE_W-1:0] MON_SOURCE_RST   = 3'd1;
  localparam logic              ENABLE_RST       = 1'b1;

  localparam logic [TMO_W-1:0] MIN_TIMEOUT_MS = 20'd2000;
  localparam logic [THR_W-1:0] UI_FLOOR_MS    = 20'd3000;

  // x / 5 == (x * DIV5_MAGIC) >> DIV5_SHIFT, exact for x below 2^24
  localparam int               DIV5_IN_W  = 24;
  localparam logic [23:0]      DIV5_MAGIC = 24'hCCCCCD;
  localparam int               DIV5_SHIFT = 26;

  typedef struct packed {
    logic [THR_W-1:0] base;
    logic [THR_W-1:0] ui;
    logic [THR_W-1:0] mon;
  } thr_t;

  typedef struct packed {
    logic ui;
    logic mon;
  } role_t;

  // scan token handed from cell to cell during a pump
  typedef struct packed {
    logic             vld;
    logic [TS_W-1:0]  now;
    logic             none_stale;
    logic             found;
    logic [IDX_W-1:0] idx;
  } scan_t;

endpackage

>>> design/mhs_thresh.sv
// ----------------------------------------------------------------------------
// mhs_thresh
// Derives the three age thresholds from the base timeout, two register stages.
// ----------------------------------------------------------------------------
module mhs_thresh (
  input  logic                      clk,
  input  logic [mhs_pkg::TMO_W-1:0] base_timeout,
  output mhs_pkg::thr_t             thr
);
  import mhs_pkg::*;

  logic [TMO_W-1:0]         tmo;
  logic [DIV5_IN_W-1:0]     x4;
  logic [DIV5_IN_W-1:0]     x9;
  logic [DIV5_IN_W-1:0]     x9h;
  logic [TMO_W-2:0]         half;
  logic [2*DIV5_IN_W-1:0]   prod_base_r;
  logic [2*DIV5_IN_W-1:0]   prod_mon_r;
  logic [THR_W-1:0]         ui_r;
  thr_t                     thr_r;

  always_comb begin
    tmo  = (base_timeout < MIN_TIMEOUT_MS) ? MIN_TIMEOUT_MS : base_timeout;
    x4   = DIV5_IN_W'({tmo, 2'b00});
    // t*9/10 == (t*9/2)/5
    x9   = DIV5_IN_W'({tmo, 3'b000}) + DIV5_IN_W'(tmo);
    x9h  = {1'b0, x9[DIV5_IN_W-1:1]};
    half = tmo[TMO_W-1:1];
  end

  always_ff @(posedge clk) begin
    prod_base_r <= x4 * DIV5_MAGIC;
    prod_mon_r  <= x9h * DIV5_MAGIC;
    ui_r        <= (THR_W'(half) > UI_FLOOR_MS) ? THR_W'(half) : UI_FLOOR_MS;
    thr_r.base  <= prod_base_r[DIV5_SHIFT +: THR_W];
    thr_r.mon   <= prod_mon_r[DIV5_SHIFT +: THR_W];
    thr_r.ui    <= ui_r;
  end

  assign thr = thr_r;

endmodule

>>> design/mhs_cell.sv
// ----------------------------------------------------------------------------
// mhs_cell
// One source: holds its last heartbeat and checks its age as the token passes.
// ----------------------------------------------------------------------------
module mhs_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mhs_pkg::IDX_W-1:0] cell_idx,
  input  mhs_pkg::role_t            role,
  input  mhs_pkg::thr_t             thr,
  input  logic                      hb_we,
  input  logic [mhs_pkg::TS_W-1:0]  hb_wdata,
  input  mhs_pkg::scan_t            scan_in,
  output mhs_pkg::scan_t            scan_out
);
  import mhs_pkg::*;

  logic [TS_W-1:0]  hb_r;
  logic [TS_W-1:0]  age;
  logic [THR_W-1:0] th;
  logic             stale;
  scan_t            scan_nxt;
  scan_t            scan_r;

  always_comb begin
    age   = scan_in.now - hb_r;
    // monitor role wins over UI role on the same source
    th    = role.mon ? thr.mon : (role.ui ? thr.ui : thr.base);
    stale = (age >= TS_W'(th));

    scan_nxt            = scan_in;
    scan_nxt.none_stale = scan_in.none_stale & ~stale;
    scan_nxt.found      = scan_in.found | stale;
    if (stale && !scan_in.found) begin
      scan_nxt.idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r <= '0;
    end else if (hb_we) begin
      hb_r <= hb_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.vld <= 1'b0;
    end else begin
      scan_r.vld <= scan_nxt.vld;
    end
    scan_r.now        <= scan_nxt.now;
    scan_r.none_stale <= scan_nxt.none_stale;
    scan_r.found      <= scan_nxt.found;
    scan_r.idx        <= scan_nxt.idx;
  end

  assign scan_out = scan_r;

endmodule

>>> design/multi_source_heartbeat_supervisor.sv
// ----------------------------------------------------------------------------
// multi_source_heartbeat_supervisor
// Heartbeat supervisor over a row of per-source cells with an APB register set.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | in_cmd, in_source, in_now_ms
//  out     | out_valid / out_ready  | out_kick, out_stale_valid, out_stale_source
//  cfg     | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
//  Restart, mark, disabled pump and the unused command: idle, then the done
//  state, then out_valid once the output register is free. Enabled pump: the
//  prep state for threshold settling, the token walks the row (one register
//  per cell), the verdict folds into the stale mark, then the output register.
//  One item is in flight at a time; in_ready is high only when idle, and the
//  next item is taken while the previous result waits in the output register.
//  Reset (rst_n low, synchronous) zeroes the timestamps and the stale mark and
//  loads the register defaults.
// ----------------------------------------------------------------------------
module multi_source_heartbeat_supervisor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mhs_pkg::CMD_W-1:0]  in_cmd,
  input  logic [mhs_pkg::SRC_W-1:0]  in_source,
  input  logic [mhs_pkg::TS_W-1:0]   in_now_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_kick,
  output logic                       out_stale_valid,
  output logic [2:0]                 out_stale_source,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mhs_pkg::ADDR_W-1:0] paddr,
  input  logic [mhs_pkg::DATA_W-1:0] pwdata,
  output logic [mhs_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import mhs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  localparam logic [1:0] PREP_LAST = 2'd2;

  // configuration
  logic [TMO_W-1:0]  base_tmo_r;
  logic [ROLE_W-1:0] ui_src_r;
  logic [ROLE_W-1:0] mon_src_r;
  logic              enable_r;
  logic              cfg_wr;

  // control
  logic [1:0]        state_r, state_nxt;
  logic [1:0]        prep_r, prep_nxt;
  logic [TS_W-1:0]   now_r, now_nxt;
  logic              kick_r, kick_nxt;
  logic              held_r, held_nxt;
  logic [IDX_W-1:0]  sidx_r, sidx_nxt;
  logic              launch;
  logic              accept;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kick_r, out_kick_nxt;
  logic              out_held_r, out_held_nxt;
  logic [2:0]        out_src_r, out_src_nxt;

  thr_t              thr;
  scan_t             chain [SOURCES+1];
  role_t             role [SOURCES];
  logic [SOURCES-1:0] hb_we;

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_tmo_r <= BASE_TIMEOUT_RST;
      ui_src_r   <= UI_SOURCE_RST;
      mon_src_r  <= MON_SOURCE_RST;
      enable_r   <= ENABLE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BASE_TIMEOUT: base_tmo_r <= pwdata[TMO_W-1:0];
        REG_UI_SOURCE:    ui_src_r   <= pwdata[ROLE_W-1:0];
        REG_MON_SOURCE:   mon_src_r  <= pwdata[ROLE_W-1:0];
        REG_ENABLE:       enable_r   <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASE_TIMEOUT: prdata = DATA_W'(base_tmo_r);
      REG_UI_SOURCE:    prdata = DATA_W'(ui_src_r);
      REG_MON_SOURCE:   prdata = DATA_W'(mon_src_r);
      REG_ENABLE:       prdata = DATA_W'(enable_r);
      default:          prdata = '0;
    endcase
  end

  mhs_thresh u_thresh (
    .clk          (clk),
    .base_timeout (base_tmo_r),
    .thr          (thr)
  );

  // --------------------------------------------------------------- cell row
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign chain[0] = '{vld: launch, now: now_r, none_stale: 1'b1, found: 1'b0,
                      idx: '0};

  for (genvar i = 0; i < SOURCES; i++) begin : g_cell
    assign role[i].ui  = (32'(ui_src_r) == 32'(i));
    assign role[i].mon = (32'(mon_src_r) == 32'(i));
    assign hb_we[i]    = accept && ((in_cmd == CMD_RESTART) ||
                         ((in_cmd == CMD_MARK) && (in_source == SRC_W'(i))));

    mhs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .role     (role[i]),
      .thr      (thr),
      .hb_we    (hb_we[i]),
      .hb_wdata (in_now_ms),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt     = state_r;
    prep_nxt      = prep_r;
    now_nxt       = now_r;
    kick_nxt      = kick_r;
    held_nxt      = held_r;
    sidx_nxt      = sidx_r;
    launch        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kick_nxt  = out_kick_r;
    out_held_nxt  = out_held_r;
    out_src_nxt   = out_src_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          now_nxt   = in_now_ms;
          kick_nxt  = 1'b0;
          prep_nxt  = '0;
          state_nxt = ST_DONE;
          if (in_cmd == CMD_RESTART) begin
            held_nxt = 1'b0;
            sidx_nxt = '0;
          end else if ((in_cmd == CMD_PUMP) && enable_r) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        // let the threshold pipeline settle on the current registers
        if (prep_r == PREP_LAST) begin
          launch    = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          prep_nxt = prep_r + 2'd1;
        end
      end
      ST_SCAN: begin
        if (chain[SOURCES].vld) begin
          state_nxt = ST_DONE;
          if (chain[SOURCES].none_stale) begin
            kick_nxt = 1'b1;
            held_nxt = 1'b0;
            sidx_nxt = '0;
          end else if (!held_r) begin
            held_nxt = 1'b1;
            sidx_nxt = chain[SOURCES].idx;
          end
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kick_nxt  = kick_r;
          out_held_nxt  = held_r;
          out_src_nxt   = held_r ? 3'(sidx_r) : 3'd0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= 1'b0;
      sidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      sidx_r      <= sidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prep_r     <= prep_nxt;
    now_r      <= now_nxt;
    kick_r     <= kick_nxt;
    out_kick_r <= out_kick_nxt;
    out_held_r <= out_held_nxt;
    out_src_r  <= out_src_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kick         = out_kick_r;
  assign out_stale_valid  = out_held_r;
  assign out_stale_source = out_src_r;

endmodule

>>> design/mhs_checker.sv
// ----------------------------------------------------------------------------
// mhs_checker
// Port-level assertions for the heartbeat supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [mhs_pkg::CMD_W-1:0]  in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_kick,
  input logic                       out_stale_valid,
  input logic [2:0]                 out_stale_source
);
  import mhs_pkg::*;

  // a kick means every source was fresh, so no stale mark may remain
  `MHS_ASSERT_ALWAYS(a_kick_clears_stale, clk, rst_n, !(out_valid && out_kick && out_stale_valid), "kick reported with a stale mark")

  `MHS_ASSERT_ALWAYS(a_idle_source_zero, clk, rst_n, !(out_valid && !out_stale_valid && (out_stale_source != 3'd0)), "stale source nonzero without a stale mark")

  // one item in flight: ready drops right after an accept
  `MHS_ASSERT_PROP(a_one_in_flight, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "item accepted while another is in flight")

  // restart into an empty output slot reports a clean result
  `MHS_ASSERT_PROP(a_restart_clean, clk, rst_n, (in_valid && in_ready && (in_cmd == CMD_RESTART) && !out_valid) |=> ##1 (out_valid && !out_kick && !out_stale_valid), "restart result missing or not clean")

  `MHS_ASSERT_PROP(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped before it was taken")

endmodule

bind multi_source_heartbeat_supervisor mhs_checker u_mhs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_cmd           (in_cmd),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kick         (out_kick),
  .out_stale_valid  (out_stale_valid),
  .out_stale_source (out_stale_source)
);

>>> sim/tb_multi_source_heartbeat_supervisor.sv
// ----------------------------------------------------------------------------
// tb_multi_source_heartbeat_supervisor
// Drives restart, mark, pump and unused-command items at the supervisor
// under several register settings, predicts each kick and stale mark from a
// local model of the heartbeat table, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_multi_source_heartbeat_supervisor;
  timeunit 1ns;
  timeprecision 1ps;

  import mhs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SEND_SWAP = 625;
  localparam int QUIET_AT  = 1250;

  typedef struct {
    bit [CMD_W-1:0] cmd;
    bit [SRC_W-1:0] source;
    bit [TS_W-1:0]  now;
  } beat_item_t;

  typedef struct {
    bit       kick;
    bit       stale_valid;
    bit [2:0] stale_source;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [SRC_W-1:0]  in_source = '0;
  logic [TS_W-1:0]   in_now_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kick;
  logic              out_stale_valid;
  logic [2:0]        out_stale_source;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  beat_item_t pending_items[$];
  verdict_t   expected_verdicts[$];
  int         issued = 0;
  int         accepted = 0;
  int         queued_total = 0;
  int         errors = 0;

  // local copy of the registers and the heartbeat table
  bit [TMO_W-1:0]  cfg_base = BASE_TIMEOUT_RST;
  bit [ROLE_W-1:0] cfg_ui = UI_SOURCE_RST;
  bit [ROLE_W-1:0] cfg_mon = MON_SOURCE_RST;
  bit              cfg_enable = ENABLE_RST;
  bit [TS_W-1:0]   last_beat[SOURCES];
  bit              stale_held = 1'b0;
  int unsigned     stale_idx = 0;

  multi_source_heartbeat_supervisor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_source        (in_source),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kick         (out_kick),
    .out_stale_valid  (out_stale_valid),
    .out_stale_source (out_stale_source),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned age_limit(int unsigned idx);
    int unsigned t;
    int unsigned lim;
    t = 32'((cfg_base < MIN_TIMEOUT_MS) ? MIN_TIMEOUT_MS : cfg_base);
    lim = t * 4 / 5;
    if (idx == cfg_ui) lim = (t / 2 > UI_FLOOR_MS) ? t / 2 : UI_FLOOR_MS;
    if (idx == cfg_mon) lim = t * 9 / 10;
    return lim;
  endfunction

  function automatic void supervise(beat_item_t it);
    verdict_t  v;
    bit        none_stale;
    bit [31:0] age;
    v.kick = 1'b0;
    case (it.cmd)
      CMD_RESTART: begin
        for (int i = 0; i < SOURCES; i++) last_beat[i] = it.now;
        stale_held = 1'b0;
        stale_idx = 0;
      end
      CMD_MARK: begin
        if (it.source < SOURCES) last_beat[it.source] = it.now;
      end
      CMD_PUMP: begin
        if (cfg_enable) begin
          none_stale = 1'b1;
          for (int i = 0; i < SOURCES; i++) begin
            age = it.now - last_beat[i];
            if (age >= age_limit(i)) begin
              none_stale = 1'b0;
              if (!stale_held) begin
                stale_held = 1'b1;
                stale_idx = i;
              end
            end
          end
          if (none_stale) begin
            v.kick = 1'b1;
            stale_held = 1'b0;
            stale_idx = 0;
          end
        end
      end
      default: ;
    endcase
    v.stale_valid = stale_held;
    v.stale_source = stale_held ? 3'(stale_idx) : 3'd0;
    expected_verdicts.push_back(v);
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: new item only once the previous one was taken
  always @(negedge clk) begin
    int send_idle;
    int recv_idle;
    beat_item_t it;
    send_idle = (issued < SEND_SWAP) ? 36 : (issued < QUIET_AT) ? 60 : 0;
    recv_idle = (issued < SEND_SWAP) ? 60 : (issued < QUIET_AT) ? 36 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (!in_valid || accepted == issued) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          it = pending_items.pop_front();
          in_cmd <= it.cmd;
          in_source <= it.source;
          in_now_ms <= it.now;
          in_valid <= 1'b1;
          issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on acceptance, check each result against the oldest
  always @(posedge clk) begin
    beat_item_t it;
    verdict_t   want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        it.cmd = in_cmd;
        it.source = in_source;
        it.now = in_now_ms;
        supervise(it);
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          note_mismatch("result with none expected", 32'(out_kick), 32'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_kick !== want.kick)
            note_mismatch("kick", 32'(out_kick), 32'(want.kick));
          if (out_stale_valid !== want.stale_valid)
            note_mismatch("stale_valid", 32'(out_stale_valid), 32'(want.stale_valid));
          if (out_stale_source !== want.stale_source)
            note_mismatch("stale_source", 32'(out_stale_source), 32'(want.stale_source));
        end
      end
    end
  end

  task automatic add_item(bit [CMD_W-1:0] cmd, bit [SRC_W-1:0] source, bit [TS_W-1:0] now);
    beat_item_t it;
    it.cmd = cmd;
    it.source = source;
    it.now = now;
    pending_items.push_back(it);
    queued_total++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE_TIMEOUT: cfg_base = value[TMO_W-1:0];
      REG_UI_SOURCE:    cfg_ui = value[ROLE_W-1:0];
      REG_MON_SOURCE:   cfg_mon = value[ROLE_W-1:0];
      REG_ENABLE:       cfg_enable = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SOURCES + 12) @(posedge clk);
  endtask

  // restart, then rounds of heartbeats followed by a pump; some noise mixed in
  task automatic queue_session(int n_items);
    int unsigned t;
    bit [TS_W-1:0] ms;
    int k;
    t = 32'((cfg_base < MIN_TIMEOUT_MS) ? MIN_TIMEOUT_MS : cfg_base);
    ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(2 * t) : $urandom;
    add_item(CMD_RESTART, SRC_W'($urandom_range(15)), ms);
    k = 1;
    if ($urandom_range(2) == 0) begin
      // land right on or just under one source's threshold
      add_item(CMD_PUMP, SRC_W'($urandom_range(15)),
               ms + age_limit($urandom_range(SOURCES - 1)) - $urandom_range(1));
      k++;
    end
    while (k < n_items) begin
      if ($urandom_range(99) < 15) begin
        add_item(CMD_W'($urandom_range(3)), SRC_W'($urandom_range(15)), $urandom);
        k++;
      end else begin
        ms += $urandom_range(t / 4);
        for (int s = 0; s < SOURCES; s++) begin
          if ($urandom_range(99) < 80) begin
            add_item(CMD_MARK, SRC_W'(s), ms);
            k++;
          end
        end
        if ($urandom_range(9) == 0) begin
          add_item(CMD_MARK, SRC_W'($urandom_range(15, SOURCES)), ms);
          k++;
        end
        ms += $urandom_range(t / 8);
        add_item(CMD_PUMP, SRC_W'($urandom_range(15)), ms);
        k++;
      end
    end
  endtask

  task automatic run_phase(int n);
    int goal;
    goal = queued_total + n;
    while (queued_total < goal) queue_session($urandom_range(8, 60));
    settle();
  endtask

  initial begin
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bit [TS_W-1:0] b;
    b = 32'hFFFF_FF00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: base 3200, ui 3000, monitor 3600
    add_item(CMD_PUMP, 4'd0, 32'd0);
    add_item(CMD_PUMP, 4'd15, 32'd3199);
    add_item(CMD_RESTART, 4'd0, b);
    add_item(CMD_MARK, 4'd15, 32'd0);
    add_item(CMD_MARK, 4'd8, 32'hFFFF_FFFF);
    add_item(CMD_PUMP, 4'd0, b + 2999);
    add_item(CMD_PUMP, 4'd0, b + 3000);
    add_item(CMD_MARK, 4'd0, b + 3000);
    add_item(CMD_PUMP, 4'd0, b + 3000);
    add_item(CMD_UNUSED, 4'd15, 32'hFFFF_FFFF);
    add_item(CMD_MARK, 4'd2, b + 3200);
    add_item(CMD_PUMP, 4'd0, b + 3200);
    for (int s = 3; s < SOURCES; s++) add_item(CMD_MARK, SRC_W'(s), b + 3300);
    add_item(CMD_PUMP, 4'd7, b + 3599);
    add_item(CMD_PUMP, 4'd0, b + 3600);
    add_item(CMD_PUMP, 4'd0, b + 6500);
    add_item(CMD_RESTART, 4'd15, 32'hFFFF_FFFF);
    add_item(CMD_PUMP, 4'd0, 32'hFFFF_FFFF);
    settle();

    run_phase(300);

    // floor of the timeout, ui and monitor on the same source
    write_reg(REG_BASE_TIMEOUT, 32'd0);
    write_reg(REG_UI_SOURCE, 32'd5);
    write_reg(REG_MON_SOURCE, 32'd5);
    run_phase(300);

    write_reg(REG_BASE_TIMEOUT, 32'h000F_FFFF);
    write_reg(REG_UI_SOURCE, 32'd7);
    write_reg(REG_MON_SOURCE, 32'd0);
    run_phase(300);

    // disabled pumps leave everything alone; state carries into the next phase
    write_reg(REG_ENABLE, 32'd0);
    write_reg(REG_BASE_TIMEOUT, 32'd1_000_000);
    write_reg(REG_UI_SOURCE, 32'd2);
    write_reg(REG_MON_SOURCE, 32'd6);
    run_phase(150);
    write_reg(REG_ENABLE, 32'd1);
    run_phase(300);

    write_reg(REG_BASE_TIMEOUT, 32'd2000);
    write_reg(REG_UI_SOURCE, 32'd1);
    write_reg(REG_MON_SOURCE, 32'd0);
    run_phase(300);

    write_reg(REG_BASE_TIMEOUT, 32'd4000);
    write_reg(REG_UI_SOURCE, 32'd0);
    write_reg(REG_MON_SOURCE, 32'd1);
    run_phase(200);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/mhs_pkg.sv
design/mhs_thresh.sv
design/mhs_cell.sv
design/multi_source_heartbeat_supervisor.sv
design/mhs_checker.sv
sim/tb_multi_source_heartbeat_supervisor.sv
